>>> hw/rtl/packed_fixed_matrix_lerp_unit_assert.svh
// ----------------------------------------------------------------------------
// packed fixed matrix lerp unit assertion macros
// shared property forms for the checker of the lerp unit
// ----------------------------------------------------------------------------
`ifndef PACKED_FIXED_MATRIX_LERP_UNIT_ASSERT_SVH
`define PACKED_FIXED_MATRIX_LERP_UNIT_ASSERT_SVH

// same-cycle implication, muted while rst is high
`define PFML_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("pfml check failed");

// next-cycle implication, muted while rst is high
`define PFML_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("pfml check failed");

`endif

>>> hw/rtl/pfml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfml_pkg
// widths, constants and types of the packed s15.16 matrix lerp unit
// ----------------------------------------------------------------------------
package pfml_pkg;

   localparam int WORD_W   = 32;
   localparam int HALF_W   = 16;
   localparam int WEIGHT_W = 17;
   localparam int LANES    = 2;
   localparam int DIFF_W   = WORD_W + 1;
   localparam int PROD_W   = DIFF_W + WEIGHT_W + 1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;

   typedef logic [WORD_W-1:0]          word_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic signed [WORD_W-1:0]   elem_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

endpackage

>>> hw/rtl/pfml_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfml_req_if
// request channel: one word pair of the previous and current matrix per beat
// ----------------------------------------------------------------------------
interface pfml_req_if;

   logic               valid;
   logic               ready;
   pfml_pkg::word_type prev_int_word;
   pfml_pkg::word_type prev_frac_word;
   pfml_pkg::word_type cur_int_word;
   pfml_pkg::word_type cur_frac_word;

   modport source (
      output valid, prev_int_word, prev_frac_word, cur_int_word, cur_frac_word,
      input  ready
   );

   modport sink (
      input  valid, prev_int_word, prev_frac_word, cur_int_word, cur_frac_word,
      output ready
   );

endinterface

>>> hw/rtl/pfml_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfml_rsp_if
// response channel: one blended word pair per beat
// ----------------------------------------------------------------------------
interface pfml_rsp_if;

   logic               valid;
   logic               ready;
   pfml_pkg::word_type out_int_word;
   pfml_pkg::word_type out_frac_word;

   modport source (
      output valid, out_int_word, out_frac_word,
      input  ready
   );

   modport sink (
      input  valid, out_int_word, out_frac_word,
      output ready
   );

endinterface

>>> hw/rtl/packed_fixed_matrix_lerp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_fixed_matrix_lerp_unit
// blends two packed s15.16 elements per beat toward the current matrix
// ----------------------------------------------------------------------------
// req carries one word pair of the previous and of the current matrix in the
// split layout (integer-half word, fraction-half word, two elements each).
// rsp returns the two blended elements packed the same way, computed as
// ((65536 - t) * p + t * c) / 65536 truncated toward zero.
// csr_wr_en / csr_wr_data write the Q1.16 weight t; values above 65536 are
// clamped to 65536. write it only while no beat is in flight.
// a beat passes the input register, then the result register, before rsp
// valid rises for it; one beat is taken every cycle while rsp drains.
// the critical path is one 18 x 33 multiply, one 51-bit add and a 32-bit
// increment for the truncation toward zero, per element.
// reset empties both stages and sets the weight to one half.
// when rsp stalls, the result register holds and the input register still
// takes one more beat; req.ready drops only when both are full.
// ----------------------------------------------------------------------------
module packed_fixed_matrix_lerp_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  pfml_pkg::weight_type     csr_wr_data,
   pfml_req_if.sink                 req,
   pfml_rsp_if.source               rsp
);

   pfml_pkg::weight_type  weight_ff, weight_in;

   logic                  s1_valid_ff, s1_valid_in;
   pfml_pkg::elem_type    s1_prev_ff [pfml_pkg::LANES];
   pfml_pkg::diff_type    s1_diff_ff [pfml_pkg::LANES];
   pfml_pkg::elem_type    prev_unp   [pfml_pkg::LANES];
   pfml_pkg::elem_type    cur_unp    [pfml_pkg::LANES];
   pfml_pkg::diff_type    diff_in    [pfml_pkg::LANES];

   logic                  rsp_valid_ff, rsp_valid_in;
   pfml_pkg::word_type    out_int_ff, out_int_in;
   pfml_pkg::word_type    out_frac_ff, out_frac_in;

   pfml_pkg::prod_type    prod  [pfml_pkg::LANES];
   pfml_pkg::prod_type    sum   [pfml_pkg::LANES];
   pfml_pkg::prod_type    quo   [pfml_pkg::LANES];
   logic                  bump  [pfml_pkg::LANES];
   pfml_pkg::word_type    blend [pfml_pkg::LANES];

   logic                  req_beat;
   logic                  out_adv;

   // handshake
   assign out_adv   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || out_adv;
   assign req_beat  = req.valid && req.ready;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_int_word  = out_int_ff;
   assign rsp.out_frac_word = out_frac_ff;

   always_comb begin
      weight_in = weight_ff;
      if (csr_wr_en) begin
         weight_in = (csr_wr_data > pfml_pkg::WEIGHT_ONE) ? pfml_pkg::WEIGHT_ONE
                                                          : csr_wr_data;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_beat) begin
         s1_valid_in = 1'b1;
      end else if (out_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;
   end

   // unpack lane 0 from the high halves, lane 1 from the low halves
   always_comb begin
      for (int i = 0; i < pfml_pkg::LANES; i++) begin
         prev_unp[i] = {req.prev_int_word[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +:
                                          pfml_pkg::HALF_W],
                        req.prev_frac_word[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +:
                                           pfml_pkg::HALF_W]};
         cur_unp[i]  = {req.cur_int_word[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +:
                                         pfml_pkg::HALF_W],
                        req.cur_frac_word[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +:
                                          pfml_pkg::HALF_W]};
         diff_in[i]  = pfml_pkg::DIFF_W'(cur_unp[i]) - pfml_pkg::DIFF_W'(prev_unp[i]);
      end
   end

   // p * 65536 + t * (c - p), then shift with rounding toward zero
   always_comb begin
      out_int_in  = '0;
      out_frac_in = '0;
      for (int i = 0; i < pfml_pkg::LANES; i++) begin
         prod[i]  = $signed({1'b0, weight_ff}) * s1_diff_ff[i];
         sum[i]   = prod[i]
                  + pfml_pkg::PROD_W'(signed'({s1_prev_ff[i], pfml_pkg::HALF_W'(0)}));
         quo[i]   = sum[i] >>> pfml_pkg::HALF_W;
         bump[i]  = sum[i][pfml_pkg::PROD_W-1] && (sum[i][pfml_pkg::HALF_W-1:0] != '0);
         blend[i] = quo[i][pfml_pkg::WORD_W-1:0] + pfml_pkg::WORD_W'(bump[i]);
         out_int_in[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +: pfml_pkg::HALF_W] =
            blend[i][pfml_pkg::WORD_W-1:pfml_pkg::HALF_W];
         out_frac_in[(pfml_pkg::LANES-1-i)*pfml_pkg::HALF_W +: pfml_pkg::HALF_W] =
            blend[i][pfml_pkg::HALF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= pfml_pkg::WEIGHT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         weight_ff    <= weight_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_prev_ff <= prev_unp;
         s1_diff_ff <= diff_in;
      end
      if (out_adv && s1_valid_ff) begin
         out_int_ff  <= out_int_in;
         out_frac_ff <= out_frac_in;
      end
   end

endmodule

>>> hw/rtl/pfml_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfml_checker
// port-level checks of the lerp unit, bound into the lerp unit module
// ----------------------------------------------------------------------------
`include "packed_fixed_matrix_lerp_unit_assert.svh"

module pfml_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pfml_pkg::word_type out_int_word,
   input pfml_pkg::word_type out_frac_word
);

   logic [1:0] beats_ff, beats_in;
   logic       in_beat;
   logic       out_beat;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   // beats accepted but not yet delivered
   always_comb begin
      beats_in = beats_ff + 2'(in_beat) - 2'(out_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= '0;
      end else begin
         beats_ff <= beats_in;
      end
   end

   `PFML_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(out_int_word) && $stable(out_frac_word))
   `PFML_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)
   `PFML_ASSERT_IMPLY(a_ready_only_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `PFML_ASSERT_IMPLY(a_two_in_flight, clock, reset, 1'b1, beats_ff != 2'd3)
   `PFML_ASSERT_IMPLY(a_no_invented, clock, reset, rsp_valid, beats_ff != 2'd0)

endmodule

bind packed_fixed_matrix_lerp_unit pfml_checker u_pfml_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .out_int_word  (rsp.out_int_word),
   .out_frac_word (rsp.out_frac_word)
);
